// ===== rtl/bfrs_pkg.sv =====
// ----------------------------------------------------------------------------
// Box filter row sum package
// Shared widths, register indexes, reset values and the control struct that
// travels with each item from the front to the back of the block.
// ----------------------------------------------------------------------------
package bfrs_pkg;

   localparam int MAX_WINDOW_DEFAULT   = 32;
   localparam int MAX_CHANNELS_DEFAULT = 4;
   localparam int SAMPLE_BITS_DEFAULT  = 16;
   localparam int QUEUE_DEPTH_DEFAULT  = 4;

   localparam int SUM_BITS         = 21;
   localparam int CHAN_OUT_BITS    = 2;
   localparam int RSP_TDATA_BITS   = ((SUM_BITS + 7) / 8) * 8;
   localparam int WINDOW_REG_BITS  = 6;
   localparam int CHANNEL_REG_BITS = 3;
   localparam int CSR_INDEX_BITS   = 2;
   localparam int CSR_DATA_BITS    = 6;

   localparam logic [CSR_INDEX_BITS-1:0] REG_WINDOW_WIDTH  = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] REG_CHANNEL_COUNT = 2'd1;

   localparam logic [WINDOW_REG_BITS-1:0]  WINDOW_WIDTH_RESET  = 6'd3;
   localparam logic [CHANNEL_REG_BITS-1:0] CHANNEL_COUNT_RESET = 3'd1;

   typedef struct packed {
      logic leave_en;
      logic emit;
      logic last;
   } ctl_type;

   localparam int CTL_BITS = $bits(ctl_type);

   function automatic int addr_bits(input int n);
      addr_bits = (n > 1) ? $clog2(n) : 1;
   endfunction

endpackage

// ===== rtl/bfrs_ram.sv =====
// ----------------------------------------------------------------------------
// Box filter row sum RAM
// Simple dual-port RAM with registered read; a read and a write at the same
// address in the same cycle return the old contents.
// ----------------------------------------------------------------------------
module bfrs_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 128
) (
   input  logic                                 clock,
   input  logic                                 we,
   input  logic [bfrs_pkg::addr_bits(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]                     wdata,
   input  logic                                 re,
   input  logic [bfrs_pkg::addr_bits(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]                     rdata
);
   import bfrs_pkg::*;

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

// ===== rtl/bfrs_front.sv =====
// ----------------------------------------------------------------------------
// Box filter row sum front end
// Holds the configuration, tracks channel, ring slot and pixel position,
// issues the history read and write, and classifies each accepted item.
// ----------------------------------------------------------------------------
module bfrs_front #(
   parameter int MAX_WINDOW   = 32,
   parameter int MAX_CHANNELS = 4,
   parameter int SAMPLE_BITS  = 16,
   parameter int QUEUE_DEPTH  = 4
) (
   input  logic                                               clock,
   input  logic                                               reset,
   input  logic                                               req_tvalid,
   output logic                                               req_tready,
   input  logic [SAMPLE_BITS-1:0]                             req_sample,
   input  logic                                               req_last,
   input  logic                                               csr_valid,
   output logic                                               csr_ready,
   input  logic [bfrs_pkg::CSR_INDEX_BITS-1:0]                csr_index,
   input  logic [bfrs_pkg::CSR_DATA_BITS-1:0]                 csr_wdata,
   input  logic [bfrs_pkg::addr_bits(QUEUE_DEPTH+1)-1:0]      q_count,
   output logic                                               ram_en,
   output logic [bfrs_pkg::addr_bits(MAX_WINDOW*MAX_CHANNELS)-1:0] ram_addr,
   output logic                                               s1_valid,
   output logic [SAMPLE_BITS-1:0]                             s1_sample,
   output logic [bfrs_pkg::addr_bits(MAX_CHANNELS)-1:0]       s1_chan,
   output bfrs_pkg::ctl_type                                  s1_ctl,
   output logic                                               row_clear
);
   import bfrs_pkg::*;

   localparam int AW   = addr_bits(MAX_WINDOW * MAX_CHANNELS);
   localparam int CI_W = addr_bits(MAX_CHANNELS);
   localparam int CN_W = $clog2(MAX_CHANNELS + 1);
   localparam int SL_W = addr_bits(MAX_WINDOW);
   localparam int PP_W = $clog2(MAX_WINDOW + 1);
   localparam int QC_W = addr_bits(QUEUE_DEPTH + 1);

   logic [WINDOW_REG_BITS-1:0]  window_width_ff,  window_width_in;
   logic [CHANNEL_REG_BITS-1:0] channel_count_ff, channel_count_in;
   logic [CI_W-1:0]             chan_pos_ff,      chan_pos_in;
   logic [SL_W-1:0]             slot_ff,          slot_in;
   logic [PP_W-1:0]             pixel_pos_ff,     pixel_pos_in;
   logic                        s1_valid_ff,      s1_valid_in;
   logic [SAMPLE_BITS-1:0]      s1_sample_ff;
   logic [CI_W-1:0]             s1_chan_ff;
   ctl_type                     s1_ctl_ff,        s1_ctl_in;

   logic [PP_W-1:0] w_eff;
   logic [CN_W-1:0] cn_eff;
   logic [CI_W-1:0] chan;
   logic [SL_W-1:0] slot;
   logic            accept;
   logic            csr_hit;
   logic            pixel_done;

   assign req_tready = ((QC_W + 1)'(q_count) + (QC_W + 1)'(s1_valid_ff))
                       < (QC_W + 1)'(QUEUE_DEPTH);
   assign accept     = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;
   assign csr_hit    = csr_valid && ((csr_index == REG_WINDOW_WIDTH) ||
                                     (csr_index == REG_CHANNEL_COUNT));
   assign row_clear  = csr_hit;

   always_comb begin
      if (window_width_ff == '0) begin
         w_eff = PP_W'(1);
      end else if (int'(window_width_ff) > MAX_WINDOW) begin
         w_eff = PP_W'(MAX_WINDOW);
      end else begin
         w_eff = PP_W'(window_width_ff);
      end

      if (channel_count_ff == '0) begin
         cn_eff = CN_W'(1);
      end else if (int'(channel_count_ff) > MAX_CHANNELS) begin
         cn_eff = CN_W'(MAX_CHANNELS);
      end else begin
         cn_eff = CN_W'(channel_count_ff);
      end

      chan = (CN_W'(chan_pos_ff) >= cn_eff) ? '0 : chan_pos_ff;
      slot = (PP_W'(slot_ff) >= w_eff) ? '0 : slot_ff;

      ram_addr = AW'(slot) * AW'(MAX_CHANNELS) + AW'(chan);
      ram_en   = accept;

      s1_ctl_in.leave_en = pixel_pos_ff >= w_eff;
      s1_ctl_in.emit     = ((PP_W + 1)'(pixel_pos_ff) + (PP_W + 1)'(1))
                           >= (PP_W + 1)'(w_eff);
      s1_ctl_in.last     = req_last;
      s1_valid_in        = accept;

      pixel_done = (CN_W'(chan) + CN_W'(1)) >= cn_eff;

      window_width_in  = window_width_ff;
      channel_count_in = channel_count_ff;
      chan_pos_in      = chan_pos_ff;
      slot_in          = slot_ff;
      pixel_pos_in     = pixel_pos_ff;

      if (accept) begin
         if (pixel_done) begin
            chan_pos_in = '0;
            slot_in     = ((PP_W'(slot) + PP_W'(1)) >= w_eff) ? '0 : slot + SL_W'(1);
            if (pixel_pos_ff < w_eff) begin
               pixel_pos_in = pixel_pos_ff + PP_W'(1);
            end
         end else begin
            chan_pos_in = chan + CI_W'(1);
            slot_in     = slot;
         end
      end

      if ((accept && req_last) || csr_hit) begin
         chan_pos_in  = '0;
         slot_in      = '0;
         pixel_pos_in = '0;
      end

      if (csr_valid && (csr_index == REG_WINDOW_WIDTH)) begin
         window_width_in = WINDOW_REG_BITS'(csr_wdata);
      end
      if (csr_valid && (csr_index == REG_CHANNEL_COUNT)) begin
         channel_count_in = csr_wdata[CHANNEL_REG_BITS-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         window_width_ff  <= WINDOW_WIDTH_RESET;
         channel_count_ff <= CHANNEL_COUNT_RESET;
         chan_pos_ff      <= '0;
         slot_ff          <= '0;
         pixel_pos_ff     <= '0;
         s1_valid_ff      <= 1'b0;
      end else begin
         window_width_ff  <= window_width_in;
         channel_count_ff <= channel_count_in;
         chan_pos_ff      <= chan_pos_in;
         slot_ff          <= slot_in;
         pixel_pos_ff     <= pixel_pos_in;
         s1_valid_ff      <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_sample_ff <= req_sample;
         s1_chan_ff   <= chan;
         s1_ctl_ff    <= s1_ctl_in;
      end
   end

   assign s1_valid  = s1_valid_ff;
   assign s1_sample = s1_sample_ff;
   assign s1_chan   = s1_chan_ff;
   assign s1_ctl    = s1_ctl_ff;

   a_chan_in_range: assert property (@(posedge clock) disable iff (reset)
      CN_W'(chan_pos_ff) < cn_eff)
      else $error("channel position beyond channel count");

   a_pixel_saturates: assert property (@(posedge clock) disable iff (reset)
      pixel_pos_ff <= w_eff)
      else $error("pixel position beyond window width");

   a_last_clears: assert property (@(posedge clock) disable iff (reset)
      (accept && req_last) |=> (pixel_pos_ff == '0) && (chan_pos_ff == '0))
      else $error("row state not cleared after last item");

endmodule

// ===== rtl/bfrs_queue.sv =====
// ----------------------------------------------------------------------------
// Box filter row sum queue
// Small first-in first-out buffer between the front and back ends.
// ----------------------------------------------------------------------------
module bfrs_queue #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  logic                                       clock,
   input  logic                                       reset,
   input  logic                                       push,
   input  logic [WIDTH-1:0]                           push_data,
   input  logic                                       pop,
   output logic                                       head_valid,
   output logic [WIDTH-1:0]                           head_data,
   output logic [bfrs_pkg::addr_bits(DEPTH+1)-1:0]    count
);
   import bfrs_pkg::*;

   localparam int PW = addr_bits(DEPTH);
   localparam int CW = addr_bits(DEPTH + 1);

   logic [WIDTH-1:0] entries_ff [DEPTH];
   logic [PW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]    count_ff,  count_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (int'(wr_ptr_ff) == DEPTH - 1) ? '0 : wr_ptr_ff + PW'(1);
      end
      if (pop) begin
         rd_ptr_in = (int'(rd_ptr_ff) == DEPTH - 1) ? '0 : rd_ptr_ff + PW'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CW'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign head_valid = count_ff != '0;
   assign head_data  = entries_ff[rd_ptr_ff];
   assign count      = count_ff;

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> (int'(count_ff) < DEPTH) || pop)
      else $error("queue push while full");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> count_ff != '0)
      else $error("queue pop while empty");

   a_count_tracks: assert property (@(posedge clock) disable iff (reset)
      (push && !pop) |=> count_ff == $past(count_ff) + CW'(1))
      else $error("queue count did not advance on push");

endmodule

// ===== rtl/bfrs_back.sv =====
// ----------------------------------------------------------------------------
// Box filter row sum back end
// Updates the per-channel running sums and drives the result register.
// ----------------------------------------------------------------------------
module bfrs_back #(
   parameter int MAX_CHANNELS = 4,
   parameter int SAMPLE_BITS  = 16
) (
   input  logic                                         clock,
   input  logic                                         reset,
   input  logic                                         row_clear,
   input  logic                                         head_valid,
   output logic                                         pop,
   input  logic [SAMPLE_BITS-1:0]                       head_sample,
   input  logic [SAMPLE_BITS-1:0]                       head_leaving,
   input  logic [bfrs_pkg::addr_bits(MAX_CHANNELS)-1:0] head_chan,
   input  bfrs_pkg::ctl_type                            head_ctl,
   output logic                                         rsp_tvalid,
   input  logic                                         rsp_tready,
   output logic [bfrs_pkg::SUM_BITS-1:0]                rsp_sum,
   output logic [bfrs_pkg::CHAN_OUT_BITS-1:0]           rsp_chan,
   output logic                                         rsp_last
);
   import bfrs_pkg::*;

   localparam int CALC_W = (SAMPLE_BITS > SUM_BITS) ? SAMPLE_BITS : SUM_BITS;

   logic [MAX_CHANNELS-1:0][SUM_BITS-1:0] sums_ff, sums_in;
   logic                                  rsp_valid_ff, rsp_valid_in;
   logic [SUM_BITS-1:0]                   rsp_sum_ff;
   logic [CHAN_OUT_BITS-1:0]              rsp_chan_ff;
   logic                                  rsp_last_ff;
   logic [CALC_W-1:0]                     calc;
   logic [SUM_BITS-1:0]                   new_sum;
   logic                                  load;

   always_comb begin
      pop  = head_valid && (!rsp_valid_ff || rsp_tready);
      load = pop && head_ctl.emit;
      calc = CALC_W'(sums_ff[head_chan]) + CALC_W'(head_sample)
             - (head_ctl.leave_en ? CALC_W'(head_leaving) : CALC_W'(0));
      new_sum = calc[SUM_BITS-1:0];

      sums_in = sums_ff;
      if (pop) begin
         sums_in[head_chan] = new_sum;
         if (head_ctl.last) begin
            sums_in = '0;
         end
      end
      if (row_clear) begin
         sums_in = '0;
      end

      rsp_valid_in = rsp_valid_ff;
      if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if (load) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sums_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         sums_ff      <= sums_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         rsp_sum_ff  <= new_sum;
         rsp_chan_ff <= CHAN_OUT_BITS'(head_chan);
         rsp_last_ff <= head_ctl.last;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_sum    = rsp_sum_ff;
   assign rsp_chan   = rsp_chan_ff;
   assign rsp_last   = rsp_last_ff;

   a_last_clears_sums: assert property (@(posedge clock) disable iff (reset)
      (pop && head_ctl.last) |=> sums_ff == '0)
      else $error("running sums not cleared after last item");

   a_cfg_clears_sums: assert property (@(posedge clock) disable iff (reset)
      row_clear |=> sums_ff == '0)
      else $error("running sums not cleared by register write");

   a_no_drop: assert property (@(posedge clock) disable iff (reset)
      load |=> rsp_valid_ff)
      else $error("result lost in output register");

endmodule

// ===== rtl/box_filter_row_window_sum_top.sv =====
// ----------------------------------------------------------------------------
// Box filter row window sum, top level
// Takes a row of interleaved channel samples and returns, for every sample
// once a full window of pixels has arrived, the sum of the last window_width
// samples of its channel.
// ----------------------------------------------------------------------------
// The block takes one sample item every clock and keeps that rate for as long
// as results are taken. An accepted item and its history read are registered,
// then written into the queue, and its result is loaded into the result
// register once the output register is free. The front end reads and writes
// the sample history in the same cycle and the back end updates one running
// sum per cycle while results are taken, so neither limits the rate.
// Rows shorter than the window give no results, and the item flagged tlast
// ends the row and clears the row state. The user writes the registers
// (index 0: window_width, index 1: channel_count) only while the block is
// idle; the block does not enforce this. A write also clears the row state.
module box_filter_row_window_sum_top #(
   parameter int MAX_WINDOW   = bfrs_pkg::MAX_WINDOW_DEFAULT,
   parameter int MAX_CHANNELS = bfrs_pkg::MAX_CHANNELS_DEFAULT,
   parameter int SAMPLE_BITS  = bfrs_pkg::SAMPLE_BITS_DEFAULT,
   parameter int QUEUE_DEPTH  = bfrs_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   input  logic [((SAMPLE_BITS+7)/8)*8-1:0]      req_tdata,   // sample
   input  logic                                  req_tlast,   // last_in_row
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   output logic [bfrs_pkg::RSP_TDATA_BITS-1:0]   rsp_tdata,   // window_sum
   output logic [bfrs_pkg::CHAN_OUT_BITS-1:0]    rsp_tuser,   // channel
   output logic                                  rsp_tlast,   // last_of_row
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [bfrs_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  logic [bfrs_pkg::CSR_DATA_BITS-1:0]    csr_wdata
);
   import bfrs_pkg::*;

   localparam int DEPTH   = MAX_WINDOW * MAX_CHANNELS;
   localparam int AW      = addr_bits(DEPTH);
   localparam int CI_W    = addr_bits(MAX_CHANNELS);
   localparam int QC_W    = addr_bits(QUEUE_DEPTH + 1);
   localparam int ENTRY_W = CTL_BITS + CI_W + 2 * SAMPLE_BITS;

   logic                   ram_en;
   logic [AW-1:0]          ram_addr;
   logic [SAMPLE_BITS-1:0] ram_rdata;
   logic                   s1_valid;
   logic [SAMPLE_BITS-1:0] s1_sample;
   logic [CI_W-1:0]        s1_chan;
   ctl_type                s1_ctl;
   logic                   row_clear;
   logic [QC_W-1:0]        q_count;
   logic                   head_valid;
   logic [ENTRY_W-1:0]     head_data;
   logic                   pop;
   ctl_type                head_ctl;
   logic [SUM_BITS-1:0]    rsp_sum;

   bfrs_front #(
      .MAX_WINDOW   (MAX_WINDOW),
      .MAX_CHANNELS (MAX_CHANNELS),
      .SAMPLE_BITS  (SAMPLE_BITS),
      .QUEUE_DEPTH  (QUEUE_DEPTH)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_sample (req_tdata[SAMPLE_BITS-1:0]),
      .req_last   (req_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .q_count    (q_count),
      .ram_en     (ram_en),
      .ram_addr   (ram_addr),
      .s1_valid   (s1_valid),
      .s1_sample  (s1_sample),
      .s1_chan    (s1_chan),
      .s1_ctl     (s1_ctl),
      .row_clear  (row_clear)
   );

   bfrs_ram #(
      .WIDTH (SAMPLE_BITS),
      .DEPTH (DEPTH)
   ) u_history (
      .clock (clock),
      .we    (ram_en),
      .waddr (ram_addr),
      .wdata (req_tdata[SAMPLE_BITS-1:0]),
      .re    (ram_en),
      .raddr (ram_addr),
      .rdata (ram_rdata)
   );

   bfrs_queue #(
      .WIDTH (ENTRY_W),
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (s1_valid),
      .push_data  ({s1_ctl, s1_chan, ram_rdata, s1_sample}),
      .pop        (pop),
      .head_valid (head_valid),
      .head_data  (head_data),
      .count      (q_count)
   );

   assign head_ctl = ctl_type'(head_data[ENTRY_W-1 -: CTL_BITS]);

   bfrs_back #(
      .MAX_CHANNELS (MAX_CHANNELS),
      .SAMPLE_BITS  (SAMPLE_BITS)
   ) u_back (
      .clock        (clock),
      .reset        (reset),
      .row_clear    (row_clear),
      .head_valid   (head_valid),
      .pop          (pop),
      .head_sample  (head_data[SAMPLE_BITS-1:0]),
      .head_leaving (head_data[2*SAMPLE_BITS-1:SAMPLE_BITS]),
      .head_chan    (head_data[2*SAMPLE_BITS+CI_W-1:2*SAMPLE_BITS]),
      .head_ctl     (head_ctl),
      .rsp_tvalid   (rsp_tvalid),
      .rsp_tready   (rsp_tready),
      .rsp_sum      (rsp_sum),
      .rsp_chan     (rsp_tuser),
      .rsp_last     (rsp_tlast)
   );

   assign rsp_tdata = RSP_TDATA_BITS'(rsp_sum);

endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Box filter row window sum regression
// Streams rows of interleaved channel samples into the block under bursty
// input timing and a stalling output, and predicts every window sum with a
// running-sum model of its own. Each result is checked field by field against
// the oldest prediction. Both registers are changed between phases across
// their full range, the out-of-range values included.
// ----------------------------------------------------------------------------
module testbench;
   import bfrs_pkg::*;

   localparam int SAMPLE_W     = SAMPLE_BITS_DEFAULT;
   localparam int CHANS        = MAX_CHANNELS_DEFAULT;
   localparam int HIST_DEPTH   = MAX_WINDOW_DEFAULT * MAX_CHANNELS_DEFAULT;
   localparam int SETTLE_CYCLES = 8;
   localparam int RANDOM_ITEMS = 1100;

   localparam logic [CSR_INDEX_BITS-1:0] REG_SPARE_A = 2'd2;
   localparam logic [CSR_INDEX_BITS-1:0] REG_SPARE_B = 2'd3;

   typedef struct packed {
      logic [SAMPLE_W-1:0] sample;
      logic                last_in_row;
   } sample_item_type;

   typedef struct packed {
      logic [SUM_BITS-1:0]      window_sum;
      logic [CHAN_OUT_BITS-1:0] channel;
      logic                     last_of_row;
   } row_sum_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                        req_tvalid = 1'b0;
   logic                        req_tready;
   logic [SAMPLE_W-1:0]         req_tdata = '0;
   logic                        req_tlast = 1'b0;
   logic                        rsp_tvalid;
   logic                        rsp_tready = 1'b0;
   logic [RSP_TDATA_BITS-1:0]   rsp_tdata;
   logic [CHAN_OUT_BITS-1:0]    rsp_tuser;
   logic                        rsp_tlast;
   logic                        csr_valid = 1'b0;
   logic                        csr_ready;
   logic [CSR_INDEX_BITS-1:0]   csr_index = '0;
   logic [CSR_DATA_BITS-1:0]    csr_wdata = '0;

   sample_item_type pending_samples[$];
   row_sum_type     expected_sums[$];
   int              error_count = 0;
   int              queued_count = 0;

   // Predictor state.
   logic [WINDOW_REG_BITS-1:0]  width_reg = WINDOW_WIDTH_RESET;
   logic [CHANNEL_REG_BITS-1:0] chan_reg = CHANNEL_COUNT_RESET;
   logic [SAMPLE_W-1:0]         sample_history_q[HIST_DEPTH];
   logic [SUM_BITS-1:0]         row_sums[CHANS] = '{default: '0};
   int                          pix_pos = 0;
   int                          chan_pos = 0;
   int                          ring_slot = 0;

   // Sender and receiver pacing.
   sample_item_type drive_item;
   int              burst_left = 0;
   int              gap_left = 0;
   int              hold_left = 0;
   int              seg_left = 0;
   int              seg_mode = 0;
   int              accepted_count = 0;

   box_filter_row_window_sum_top dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   function automatic int clamp_width(input logic [WINDOW_REG_BITS-1:0] v);
      if (v == 0) return 1;
      if (v > MAX_WINDOW_DEFAULT) return MAX_WINDOW_DEFAULT;
      return int'(v);
   endfunction

   function automatic int clamp_channels(input logic [CHANNEL_REG_BITS-1:0] v);
      if (v == 0) return 1;
      if (v > MAX_CHANNELS_DEFAULT) return MAX_CHANNELS_DEFAULT;
      return int'(v);
   endfunction

   function automatic void clear_row_state();
      row_sums = '{default: '0};
      pix_pos = 0;
      chan_pos = 0;
      ring_slot = 0;
   endfunction

   function automatic void apply_reg_write(input logic [CSR_INDEX_BITS-1:0] index,
                                           input logic [CSR_DATA_BITS-1:0] value);
      case (index)
         REG_WINDOW_WIDTH: begin
            width_reg = value[WINDOW_REG_BITS-1:0];
            clear_row_state();
         end
         REG_CHANNEL_COUNT: begin
            chan_reg = value[CHANNEL_REG_BITS-1:0];
            clear_row_state();
         end
         default: ;
      endcase
   endfunction

   function automatic void predict_window_sum(input logic [SAMPLE_W-1:0] s, input logic last);
      int                  eff_w;
      int                  eff_c;
      int                  c;
      int                  slot;
      int                  idx;
      logic [SAMPLE_W-1:0] leaving;
      logic [SUM_BITS-1:0] new_sum;
      row_sum_type         res;
      eff_w = clamp_width(width_reg);
      eff_c = clamp_channels(chan_reg);
      c = (chan_pos >= eff_c) ? 0 : chan_pos;
      slot = (ring_slot >= eff_w) ? 0 : ring_slot;
      idx = slot * CHANS + c;
      leaving = (pix_pos >= eff_w) ? sample_history_q[idx] : '0;
      new_sum = row_sums[c] + s - leaving;
      row_sums[c] = new_sum;
      sample_history_q[idx] = s;
      if (pix_pos + 1 >= eff_w) begin
         res.window_sum = new_sum;
         res.channel = c[CHAN_OUT_BITS-1:0];
         res.last_of_row = last;
         expected_sums.push_back(res);
      end
      if (c + 1 >= eff_c) begin
         c = 0;
         slot = (slot + 1 >= eff_w) ? 0 : slot + 1;
         if (pix_pos < eff_w) pix_pos++;
      end else begin
         c++;
      end
      chan_pos = c;
      ring_slot = slot;
      if (last) clear_row_state();
   endfunction

   // Sender: bursts of random length separated by random gaps.
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_tready) begin
         if (gap_left > 0) begin
            gap_left--;
            req_tvalid <= 1'b0;
         end else if (pending_samples.size() != 0) begin
            drive_item = pending_samples.pop_front();
            req_tvalid <= 1'b1;
            req_tdata <= drive_item.sample;
            req_tlast <= drive_item.last_in_row;
            if (burst_left > 1) begin
               burst_left--;
            end else begin
               burst_left = $urandom_range(1, 24);
               gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            end
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // Receiver: stall pattern in segments, plus a long hold-off now and then.
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            accepted_count++;
            if (accepted_count % 350 == 0) hold_left = 80;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else begin
            if (seg_left == 0) begin
               seg_mode = $urandom_range(0, 3);
               seg_left = $urandom_range(4, 40);
            end
            seg_left--;
            case (seg_mode)
               0: rsp_tready <= 1'b1;
               1: rsp_tready <= $urandom_range(0, 1);
               2: rsp_tready <= ($urandom_range(0, 3) != 0);
               default: rsp_tready <= ($urandom_range(0, 4) == 0);
            endcase
         end
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready) predict_window_sum(req_tdata, req_tlast);
         if (csr_valid && csr_ready) apply_reg_write(csr_index, csr_wdata);
      end
   end

   always @(posedge clock) begin
      row_sum_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_sums.size() == 0) begin
            $display("%0t: unexpected result, expected none, actual sum=%0d ch=%0d last=%0d",
                     $time, rsp_tdata, rsp_tuser, rsp_tlast);
            error_count++;
         end else begin
            want = expected_sums.pop_front();
            if (rsp_tdata !== RSP_TDATA_BITS'(want.window_sum) || rsp_tuser !== want.channel ||
                rsp_tlast !== want.last_of_row) begin
               $display("%0t: expected sum=%0d ch=%0d last=%0d, actual sum=%0d ch=%0d last=%0d",
                        $time, want.window_sum, want.channel, want.last_of_row,
                        rsp_tdata, rsp_tuser, rsp_tlast);
               error_count++;
            end
         end
      end
   end

   function automatic logic [SAMPLE_W-1:0] pick_sample();
      case ($urandom_range(0, 7))
         0: return '0;
         1: return '1;
         2: return SAMPLE_W'($urandom_range(65000, 65535));
         default: return SAMPLE_W'($urandom);
      endcase
   endfunction

   task automatic push_sample(input logic [SAMPLE_W-1:0] s, input logic last);
      sample_item_type item;
      item.sample = s;
      item.last_in_row = last;
      pending_samples.push_back(item);
      queued_count++;
   endtask

   task automatic push_pixels(input int pixels, input int chans, input logic last);
      for (int i = 0; i < pixels * chans; i++)
         push_sample(pick_sample(), last && (i == pixels * chans - 1));
   endtask

   task automatic push_random_row(input int eff_w, input int eff_c);
      int kind;
      int extra;
      kind = $urandom_range(0, 9);
      case (kind)
         0: push_pixels($urandom_range(1, eff_w), eff_c, 1'b1);
         1: begin
            push_pixels(eff_w + $urandom_range(0, 4), eff_c, 1'b0);
            extra = (eff_c > 1) ? $urandom_range(1, eff_c - 1) : 1;
            for (int i = 0; i < extra; i++) push_sample(pick_sample(), i == extra - 1);
         end
         2: begin
            extra = $urandom_range(1, 8);
            for (int i = 0; i < extra; i++)
               push_sample(pick_sample(), $urandom_range(0, 3) == 0);
         end
         default: push_pixels(eff_w + $urandom_range(0, 10), eff_c, 1'b1);
      endcase
   endtask

   task automatic wait_drained();
      do @(posedge clock);
      while (pending_samples.size() != 0 || req_tvalid || expected_sums.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_INDEX_BITS-1:0] index,
                            input logic [CSR_DATA_BITS-1:0] value);
      wait_drained();
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      do @(posedge clock);
      while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   task automatic write_config(input logic [WINDOW_REG_BITS-1:0] w,
                               input logic [CHANNEL_REG_BITS-1:0] c);
      logic [CSR_DATA_BITS-1:0] v;
      v = CSR_DATA_BITS'($urandom);
      v[CHANNEL_REG_BITS-1:0] = c;
      write_reg(REG_WINDOW_WIDTH, w);
      write_reg(REG_CHANNEL_COUNT, v);
   endtask

   initial begin
      int phase_width[7];
      int phase_chans[7];
      int p;
      int budget;
      int eff_w;
      int eff_c;
      phase_width = '{32, 1, 63, 0, 33, 2, 5};
      phase_chans = '{4, 1, 7, 0, 5, 3, 2};
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // Reset settings: window of three, one channel.
      push_sample('1, 1'b0);
      push_sample('1, 1'b0);
      push_sample('1, 1'b0);
      push_sample('0, 1'b0);
      push_sample('1, 1'b1);
      push_sample(16'd7, 1'b0);
      push_sample(16'd9, 1'b1);
      push_sample(16'd1, 1'b0);
      push_sample(16'd2, 1'b0);
      push_sample(16'd3, 1'b0);
      // The unfinished row above must be cleared by the register write.
      write_reg(REG_WINDOW_WIDTH, 6'd1);
      push_sample('1, 1'b1);
      write_reg(REG_CHANNEL_COUNT, 6'd2);
      push_sample(16'd10, 1'b0);
      push_sample(16'd20, 1'b0);
      push_sample(16'd30, 1'b1);
      push_sample(16'd40, 1'b0);
      push_sample(16'd50, 1'b1);
      write_config(6'd0, 3'd0);
      push_sample(16'd5, 1'b0);
      push_sample('1, 1'b0);
      push_sample(16'd6, 1'b1);
      queued_count = 0;

      p = 0;
      while (queued_count < RANDOM_ITEMS) begin
         if (p < 7) begin
            write_config(WINDOW_REG_BITS'(phase_width[p]),
                         CHANNEL_REG_BITS'(phase_chans[p]));
         end else if ($urandom_range(0, 3) == 0) begin
            write_reg(REG_WINDOW_WIDTH, CSR_DATA_BITS'($urandom_range(0, 63)));
         end else begin
            write_config(WINDOW_REG_BITS'($urandom_range(0, 63)),
                         CHANNEL_REG_BITS'($urandom_range(0, 7)));
         end
         eff_w = clamp_width(width_reg);
         eff_c = clamp_channels(chan_reg);
         if (p == 5) begin
            // Pause mid-row until drained; writes to unused indexes keep the row.
            push_pixels(4, eff_c, 1'b0);
            write_reg(REG_SPARE_A, CSR_DATA_BITS'($urandom));
            write_reg(REG_SPARE_B, '1);
            push_pixels(3, eff_c, 1'b1);
         end
         budget = queued_count + $urandom_range(60, 140);
         if (budget > RANDOM_ITEMS) budget = RANDOM_ITEMS;
         while (queued_count < budget) push_random_row(eff_w, eff_c);
         p++;
      end

      wait_drained();
      if (expected_sums.size() != 0) begin
         $display("%0t: %0d expected results never arrived", $time, expected_sums.size());
         error_count++;
      end
      if (error_count == 0) begin
         $display("box_filter_row_window_sum_top regression: pass");
      end else begin
         $display("box_filter_row_window_sum_top regression: fail");
      end
      $finish;
   end

   initial begin
      #1_000_000;
      $display("%0t: timeout", $time);
      $display("box_filter_row_window_sum_top regression: fail");
      $finish;
   end

endmodule
